// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property checked at every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Consequent checked in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/arc_pkg.sv =====
package arc_pkg;

   // Operand width on the request channel
   localparam int DATA_W = 32;
   localparam int REQ_W  = 2 * DATA_W;
   localparam int RSP_W  = 8;
   localparam int KIND_W = 3;
   localparam int OPB_W  = 6;

   // Register indexes on the csr port
   localparam logic REG_CELL_KIND    = 1'b0;
   localparam logic REG_OPERAND_BITS = 1'b1;

   localparam logic [OPB_W-1:0] OPERAND_BITS_RESET = 6'd32;

   // Full-adder cell kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_EXACT  = 3'd0,
      KIND_SMA    = 3'd1,
      KIND_AMA1   = 3'd2,
      KIND_AMA2   = 3'd3,
      KIND_AXA2   = 3'd4,
      KIND_AXA3   = 3'd5,
      KIND_BUFFER = 3'd6
   } kind_type;

   // Carry-out truth tables, bit k is the carry for index {b, ~a, cin} = k
   localparam logic [7:0] MASK_MAJORITY = 8'hE8;
   localparam logic [7:0] MASK_SMA      = 8'hEC;
   localparam logic [7:0] MASK_AMA2     = 8'hF0;
   localparam logic [7:0] MASK_BUFFER   = 8'hCC;

   // One item as it travels down the row of cells
   typedef struct packed {
      logic              valid;
      logic              carry;
      logic [DATA_W-1:0] left;
      logic [DATA_W-1:0] right;
   } stage_type;

   function automatic logic cell_carry(input logic [KIND_W-1:0] kind,
                                       input logic b_bit,
                                       input logic na_bit,
                                       input logic cin);
      logic [7:0] mask;
      case (kind)
         KIND_SMA, KIND_AMA1: mask = MASK_SMA;
         KIND_AMA2:           mask = MASK_AMA2;
         KIND_BUFFER:         mask = MASK_BUFFER;
         default:             mask = MASK_MAJORITY;
      endcase
      return mask[{b_bit, na_bit, cin}];
   endfunction

endpackage

// ===== hdl/arc_cell.sv =====
module arc_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic [arc_pkg::KIND_W-1:0]     kind,
   input  logic [CNT_W-1:0]               count,
   input  arc_pkg::stage_type             up,
   output arc_pkg::stage_type             down
);

   logic               b_bit;
   logic               na_bit;
   logic               carry_in;
   arc_pkg::stage_type down_ff;

   // Operand bits for this position; above the input width a is 0 and b is 0
   generate
      if (IDX < arc_pkg::DATA_W) begin : g_in_range
         assign b_bit  = up.right[IDX];
         assign na_bit = ~up.left[IDX];
      end else begin : g_above
         assign b_bit  = 1'b0;
         assign na_bit = 1'b1;
      end
   endgenerate

   // Cells beyond the active width pass the carry unchanged
   always_comb begin
      if (CNT_W'(IDX) < count) begin
         carry_in = arc_pkg::cell_carry(kind, b_bit, na_bit, up.carry);
      end else begin
         carry_in = up.carry;
      end
   end

   // Valid bit is control, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (enable) begin
         down_ff.valid <= up.valid;
      end
      if (enable) begin
         down_ff.carry <= carry_in;
         down_ff.left  <= up.left;
         down_ff.right <= up.right;
      end
   end

   assign down = down_ff;

endmodule

// ===== hdl/approx_ripple_comparator_top.sv =====
// A request loads cell 0 when accepted, passes one cell per bit, then the output reg.
// Throughput: one item per cycle; the row of MAX_BITS cells is fully pipelined.
// A stalled rsp side fills bubbles first; req_tready drops only when every cell and
// the output register are full and rsp_tready is low.
// Reset: synchronous, clears all valid bits, cell_kind to exact and operand_bits to 32.
`include "assert_macros.svh"
module approx_ripple_comparator_top #(
   parameter int MAX_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // req_tdata: left_value [31:0], right_value [63:32]
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [arc_pkg::REQ_W-1:0]  req_tdata,
   // rsp_tdata: not_greater [0], zero fill [7:1]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [arc_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [arc_pkg::OPB_W-1:0]  csr_data
);

   localparam int CNT_W = $clog2(MAX_BITS + 1);

   logic [arc_pkg::KIND_W-1:0] cell_kind_ff;
   logic [arc_pkg::OPB_W-1:0]  operand_bits_ff;
   logic [7:0]                 opb_wide;
   logic [7:0]                 max_wide;
   logic [CNT_W-1:0]           count;
   arc_pkg::stage_type         head;
   arc_pkg::stage_type         link [MAX_BITS+1];
   logic [MAX_BITS-1:0]        cell_valid;
   logic [MAX_BITS:0]          advance;
   logic                       out_valid_ff;
   logic                       out_valid_in;
   logic                       out_bit_ff;
   logic                       out_load;

   // Configuration registers, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_kind_ff    <= arc_pkg::KIND_EXACT;
         operand_bits_ff <= arc_pkg::OPERAND_BITS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            arc_pkg::REG_CELL_KIND:    cell_kind_ff    <= csr_data[arc_pkg::KIND_W-1:0];
            arc_pkg::REG_OPERAND_BITS: operand_bits_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Active width, clamped to the length of the row
   assign opb_wide = 8'(operand_bits_ff);
   assign max_wide = 8'(MAX_BITS);
   assign count    = (opb_wide > max_wide) ? CNT_W'(MAX_BITS) : CNT_W'(opb_wide);

   // Item entering the row, carry-in of one for b + ~a + 1
   assign head.valid = req_tvalid;
   assign head.carry = 1'b1;
   assign head.left  = req_tdata[arc_pkg::DATA_W-1:0];
   assign head.right = req_tdata[arc_pkg::REQ_W-1:arc_pkg::DATA_W];
   assign link[0]    = head;

   // A cell moves on when it is empty or its neighbour moves on
   always_comb begin
      advance[MAX_BITS] = !out_valid_ff || rsp_tready;
      for (int i = MAX_BITS - 1; i >= 0; i--) begin
         advance[i] = !cell_valid[i] || advance[i+1];
      end
   end

   assign req_tready = advance[0];

   // Row of cells, one bit position each
   for (genvar g = 0; g < MAX_BITS; g++) begin : g_cell
      arc_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (advance[g]),
         .kind   (cell_kind_ff),
         .count  (count),
         .up     (link[g]),
         .down   (link[g+1])
      );
      assign cell_valid[g] = link[g+1].valid;
   end

   // Output register
   assign out_load     = advance[MAX_BITS] && link[MAX_BITS].valid;
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_bit_ff <= link[MAX_BITS].carry;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(arc_pkg::RSP_W-1){1'b0}}, out_bit_ff};

   // With no active bits the answer is the carry-in
   `ASSERT_IMPL(a_zero_width, clock, reset, rsp_tvalid && $stable(count) && count == '0 && $past(rsp_tvalid) == 1'b0, rsp_tdata[0], "zero width must give not_greater")
   // Input stalls only when the whole row and the output register are full
   `ASSERT_IMPL(a_stall_full, clock, reset, !req_tready, (&cell_valid) && out_valid_ff, "req stalled with a free slot")
   // A new result only comes from an item leaving the last cell
   `ASSERT_IMPL(a_out_source, clock, reset, $rose(rsp_tvalid), $past(link[MAX_BITS].valid), "result without item")

endmodule
